@@ hw/rtl/dense_matrix_multiply_top_defines.svh @@
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top_defines
// Assertion macros shared by the matrix multiply RTL.
// ----------------------------------------------------------------------------
`ifndef DENSE_MATRIX_MULTIPLY_TOP_DEFINES_SVH
`define DENSE_MATRIX_MULTIPLY_TOP_DEFINES_SVH

// same-cycle implication, clocked on clk_i, off during reset
`define DMM_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define DMM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/dmm_pkg.sv @@
// ----------------------------------------------------------------------------
// dmm_pkg
// Shared types and constants of the dense matrix multiply block.
// ----------------------------------------------------------------------------
package dmm_pkg;

  localparam int unsigned MAX_DIM_DEF = 8;

  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned IDX_W   = 3;   // row/col fields of the ports
  localparam int unsigned ELEM_W  = 16;  // Q8.8
  localparam int unsigned PROD_W  = 32;  // Q16.16 single product
  localparam int unsigned SUM_W   = 35;  // Q16.16 sum of up to 8 products
  localparam int unsigned CFG_W   = 4;
  localparam int unsigned CFG_IDX_W = 2;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_LOAD_A  = 2'd0,
    FUNC_LOAD_B  = 2'd1,
    FUNC_COMPUTE = 2'd2
  } func_e;

  localparam logic [CFG_IDX_W-1:0] REG_ROWS_A    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COLS_B    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd2;

  localparam logic [CFG_W-1:0] DIM_RESET = 4'd8;

  // write select toward the element stores
  typedef struct packed {
    logic a;
    logic b;
  } store_wr_t;

endpackage

@@ hw/rtl/dmm_store.sv @@
// ----------------------------------------------------------------------------
// dmm_store
// Element stores for A and B, one write port shared, one registered read
// port per matrix.
// ----------------------------------------------------------------------------
module dmm_store #(
  parameter int unsigned MAX_DIM = dmm_pkg::MAX_DIM_DEF,
  parameter int unsigned ADDR_W  = 6
) (
  input  logic                        clk_i,
  input  dmm_pkg::store_wr_t          wr_sel_i,
  input  logic [ADDR_W-1:0]           wr_addr_i,
  input  logic [dmm_pkg::ELEM_W-1:0]  wr_data_i,
  input  logic [ADDR_W-1:0]           rd_addr_a_i,
  input  logic [ADDR_W-1:0]           rd_addr_b_i,
  output logic [dmm_pkg::ELEM_W-1:0]  rd_data_a_o,
  output logic [dmm_pkg::ELEM_W-1:0]  rd_data_b_o
);
  import dmm_pkg::*;

  localparam int unsigned DEPTH = MAX_DIM * MAX_DIM;

  logic [ELEM_W-1:0] mem_a [DEPTH];
  logic [ELEM_W-1:0] mem_b [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_sel_i.a) begin
      mem_a[wr_addr_i] <= wr_data_i;
    end
    rd_data_a_o <= mem_a[rd_addr_a_i];
  end

  always_ff @(posedge clk_i) begin
    if (wr_sel_i.b) begin
      mem_b[wr_addr_i] <= wr_data_i;
    end
    rd_data_b_o <= mem_b[rd_addr_b_i];
  end

endmodule

@@ hw/rtl/dense_matrix_multiply_top.sv @@
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top
// C = A * B over signed Q8.8 elements, exact Q16.16 sums, column-major output.
// ----------------------------------------------------------------------------
// Usage:
//   Command channel: start/busy. A beat is taken when start is high and busy
//   is low. func selects load A element, load B element or compute.
//   Loads write the element store at the taking edge; busy stays low, so
//   loads can go back to back.
//   A compute walks j (column), i (row), r (inner index) with one
//   multiply-accumulate per cycle from the two element memories. busy is
//   high from the taking edge until the final result is strobed; results
//   are paced by the MAC walk through the single read port of each memory.
//   A compute with zero rows or zero columns starts nothing.
//   Results: valid_o marks each beat for one cycle, last_o marks the final
//   element. The receiver cannot stall; every strobe is a delivered beat.
//   Config: cfg_we_i/cfg_idx_i/cfg_data_i, written only while idle;
//   the block itself does not enforce this. Reset: config registers go
//   to 8, pipeline empties; element stores hold no defined value until loaded.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_top #(
  parameter int unsigned MAX_DIM = dmm_pkg::MAX_DIM_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [dmm_pkg::FUNC_W-1:0]    func_i,
  input  logic [dmm_pkg::IDX_W-1:0]     row_index_i,
  input  logic [dmm_pkg::IDX_W-1:0]     col_index_i,
  input  logic signed [dmm_pkg::ELEM_W-1:0] elem_value_i,
  input  logic                          cfg_we_i,
  input  logic [dmm_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmm_pkg::CFG_W-1:0]     cfg_data_i,
  output logic                          valid_o,
  output logic [dmm_pkg::IDX_W-1:0]     out_row_o,
  output logic [dmm_pkg::IDX_W-1:0]     out_col_o,
  output logic signed [dmm_pkg::SUM_W-1:0] product_value_o,
  output logic                          last_o
);
  import dmm_pkg::*;

  `include "dense_matrix_multiply_top_defines.svh"

  localparam int unsigned DIM_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int unsigned CNT_W  = $clog2(MAX_DIM + 1);
  localparam int unsigned ADDR_W = (MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

  typedef struct packed {
    logic [DIM_W-1:0] row;
    logic [DIM_W-1:0] col;
    logic             first;
    logic             last_r;
    logic             last_all;
  } tag_t;

  // ---------------- configuration ----------------
  logic [CFG_W-1:0] rows_a_q, cols_b_q, inner_dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_a_q    <= DIM_RESET;
      cols_b_q    <= DIM_RESET;
      inner_dim_q <= DIM_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ROWS_A:    rows_a_q    <= cfg_data_i;
        REG_COLS_B:    cols_b_q    <= cfg_data_i;
        REG_INNER_DIM: inner_dim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // values above MAX_DIM act as MAX_DIM
  logic [CNT_W-1:0] m_lim, n_lim, k_lim, k_step;
  logic             k_zero;

  always_comb begin
    m_lim  = (rows_a_q    > CFG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(rows_a_q);
    n_lim  = (cols_b_q    > CFG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(cols_b_q);
    k_lim  = (inner_dim_q > CFG_W'(MAX_DIM)) ? CNT_W'(MAX_DIM) : CNT_W'(inner_dim_q);
    k_zero = (k_lim == '0);
    // zero inner dim: one pass per element with the product forced to zero
    k_step = k_zero ? CNT_W'(1) : k_lim;
  end

  // ---------------- command decode ----------------
  logic  take;
  func_e func;
  logic  ld_in_range;
  logic  go_compute;
  store_wr_t wr_sel;
  logic [ADDR_W-1:0] wr_addr;

  always_comb begin
    take        = start && !busy;
    func        = func_e'(func_i);
    ld_in_range = ({1'b0, row_index_i} < (IDX_W+1)'(MAX_DIM)) &&
                  ({1'b0, col_index_i} < (IDX_W+1)'(MAX_DIM));
    wr_sel      = '0;
    go_compute  = 1'b0;
    if (take) begin
      case (func)
        FUNC_LOAD_A:  wr_sel.a   = ld_in_range;
        FUNC_LOAD_B:  wr_sel.b   = ld_in_range;
        FUNC_COMPUTE: go_compute = (m_lim != '0) && (n_lim != '0);
        default: ;
      endcase
    end
    wr_addr = ADDR_W'(row_index_i) * ADDR_W'(MAX_DIM) + ADDR_W'(col_index_i);
  end

  // ---------------- sequencer ----------------
  logic             active_q;
  logic [DIM_W-1:0] i_q, j_q, r_q;
  logic             r_end, i_end, j_end;
  tag_t             issue_tag;
  logic [ADDR_W-1:0] rd_addr_a, rd_addr_b;

  always_comb begin
    r_end = (CNT_W'(r_q) + CNT_W'(1)) == k_step;
    i_end = (CNT_W'(i_q) + CNT_W'(1)) == m_lim;
    j_end = (CNT_W'(j_q) + CNT_W'(1)) == n_lim;
    issue_tag.row      = i_q;
    issue_tag.col      = j_q;
    issue_tag.first    = (r_q == '0);
    issue_tag.last_r   = r_end;
    issue_tag.last_all = r_end && i_end && j_end;
    rd_addr_a = ADDR_W'(i_q) * ADDR_W'(MAX_DIM) + ADDR_W'(r_q);
    rd_addr_b = ADDR_W'(r_q) * ADDR_W'(MAX_DIM) + ADDR_W'(j_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      i_q      <= '0;
      j_q      <= '0;
      r_q      <= '0;
    end else if (go_compute) begin
      active_q <= 1'b1;
      i_q      <= '0;
      j_q      <= '0;
      r_q      <= '0;
    end else if (active_q) begin
      if (!r_end) begin
        r_q <= r_q + DIM_W'(1);
      end else begin
        r_q <= '0;
        if (!i_end) begin
          i_q <= i_q + DIM_W'(1);
        end else begin
          i_q <= '0;
          if (!j_end) begin
            j_q <= j_q + DIM_W'(1);
          end else begin
            active_q <= 1'b0;
          end
        end
      end
    end
  end

  // ---------------- element stores ----------------
  logic [ELEM_W-1:0] rd_data_a, rd_data_b;

  dmm_store #(
    .MAX_DIM (MAX_DIM),
    .ADDR_W  (ADDR_W)
  ) u_store (
    .clk_i       (clk_i),
    .wr_sel_i    (wr_sel),
    .wr_addr_i   (wr_addr),
    .wr_data_i   (elem_value_i),
    .rd_addr_a_i (rd_addr_a),
    .rd_addr_b_i (rd_addr_b),
    .rd_data_a_o (rd_data_a),
    .rd_data_b_o (rd_data_b)
  );

  // ---------------- MAC pipeline ----------------
  logic s1_valid_q, s2_valid_q;
  tag_t s1_tag_q, s2_tag_q;
  logic signed [PROD_W-1:0] prod_d, prod_q;
  logic signed [SUM_W-1:0]  acc_d, acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      s1_valid_q <= active_q;
      s2_valid_q <= s1_valid_q;
      valid_o    <= s2_valid_q && s2_tag_q.last_r;
    end
  end

  always_comb begin
    prod_d = k_zero ? '0 : PROD_W'($signed(rd_data_a) * $signed(rd_data_b));
    acc_d  = (s2_tag_q.first ? '0 : acc_q) + SUM_W'(prod_q);
  end

  always_ff @(posedge clk_i) begin
    s1_tag_q <= issue_tag;
    s2_tag_q <= s1_tag_q;
    prod_q   <= prod_d;
    if (s2_valid_q) begin
      acc_q <= acc_d;
    end
    if (s2_valid_q && s2_tag_q.last_r) begin
      out_row_o       <= IDX_W'(s2_tag_q.row);
      out_col_o       <= IDX_W'(s2_tag_q.col);
      product_value_o <= acc_d;
      last_o          <= s2_tag_q.last_all;
    end
  end

  assign busy = active_q || s1_valid_q || s2_valid_q;

  // ---------------- assertions ----------------
  `DMM_ASSERT_SAME(a_last_drains, valid_o && last_o, !busy, "busy after final element")
  `DMM_ASSERT_NEXT(a_walk_ends, active_q && issue_tag.last_all, !active_q, "sequencer overran")
  `DMM_ASSERT_NEXT(a_emit_on_end, s2_valid_q && s2_tag_q.last_r, valid_o, "element not emitted")
  `DMM_ASSERT_SAME(a_no_load_busy, busy, wr_sel == '0, "store written during compute")

endmodule
